// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_STRING  = 2'd1,
        PH_ESCAPE  = 2'd2,
        PH_UNICODE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_cnt;
        logic [15:0] hex_acc;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       byte_valid;
        status_t    status;
    } dec_result_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CODE_BS   = 8'h08;
    localparam logic [7:0] CODE_FF   = 8'h0C;
    localparam logic [7:0] CODE_LF   = 8'h0A;
    localparam logic [7:0] CODE_CR   = 8'h0D;
    localparam logic [7:0] CODE_TAB  = 8'h09;
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] REPL_RESET = 8'h3F;

endpackage

// ===== hdl/jsu_decode.sv =====
module jsu_decode (
    input  jsu_pkg::dec_state_t  state_cur,
    input  logic [7:0]           text_byte,
    input  logic [7:0]           replacement_char,
    output jsu_pkg::dec_state_t  state_next,
    output jsu_pkg::dec_result_t result
);

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_shifted;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
            hex_val = 4'(text_byte - 8'h30);
        end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
            hex_val = 4'(text_byte - 8'h57);
        end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
            hex_val = 4'(text_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_shifted = {state_cur.hex_acc[11:0], hex_val};

    always_comb begin
        state_next          = state_cur;
        result.decoded_byte = 8'd0;
        result.byte_valid   = 1'b0;
        result.status       = jsu_pkg::ST_CONT;

        unique case (state_cur.phase)
            jsu_pkg::PH_WAIT: begin
                if (text_byte == jsu_pkg::CH_QUOTE) begin
                    state_next.phase = jsu_pkg::PH_STRING;
                end else begin
                    result.status = jsu_pkg::ST_ERR;
                end
            end
            jsu_pkg::PH_STRING: begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    result.status    = jsu_pkg::ST_ERR;
                    state_next.phase = jsu_pkg::PH_WAIT;
                end else if (text_byte == jsu_pkg::CH_QUOTE) begin
                    result.status    = jsu_pkg::ST_DONE;
                    state_next.phase = jsu_pkg::PH_WAIT;
                end else if (text_byte == jsu_pkg::CH_BSLASH) begin
                    state_next.phase = jsu_pkg::PH_ESCAPE;
                end else begin
                    result.decoded_byte = text_byte;
                    result.byte_valid   = 1'b1;
                end
            end
            jsu_pkg::PH_ESCAPE: begin
                state_next.phase  = jsu_pkg::PH_STRING;
                result.byte_valid = 1'b1;
                unique case (text_byte)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
                        result.decoded_byte = text_byte;
                    end
                    jsu_pkg::CH_B: result.decoded_byte = jsu_pkg::CODE_BS;
                    jsu_pkg::CH_F: result.decoded_byte = jsu_pkg::CODE_FF;
                    jsu_pkg::CH_N: result.decoded_byte = jsu_pkg::CODE_LF;
                    jsu_pkg::CH_R: result.decoded_byte = jsu_pkg::CODE_CR;
                    jsu_pkg::CH_T: result.decoded_byte = jsu_pkg::CODE_TAB;
                    jsu_pkg::CH_U: begin
                        result.byte_valid  = 1'b0;
                        state_next.phase   = jsu_pkg::PH_UNICODE;
                        state_next.hex_cnt = 2'd0;
                        state_next.hex_acc = 16'd0;
                    end
                    default: begin
                        result.byte_valid = 1'b0;
                        result.status     = jsu_pkg::ST_ERR;
                        state_next.phase  = jsu_pkg::PH_WAIT;
                    end
                endcase
            end
            jsu_pkg::PH_UNICODE: begin
                if (!hex_ok) begin
                    result.status    = jsu_pkg::ST_ERR;
                    state_next.phase = jsu_pkg::PH_WAIT;
                end else begin
                    state_next.hex_acc = acc_shifted;
                    if (state_cur.hex_cnt == 2'd3) begin
                        // Codes beyond 7-bit ASCII collapse to the replacement byte.
                        result.decoded_byte = (acc_shifted[15:7] == 9'd0)
                                              ? acc_shifted[7:0] : replacement_char;
                        result.byte_valid   = 1'b1;
                        state_next.hex_cnt  = 2'd0;
                        state_next.phase    = jsu_pkg::PH_STRING;
                    end else begin
                        state_next.hex_cnt = state_cur.hex_cnt + 2'd1;
                    end
                end
            end
            default: begin
                state_next.phase = jsu_pkg::PH_WAIT;
            end
        endcase
    end

endmodule

// ===== hdl/json_string_unescape_decoder.sv =====
// JSON string unescape decoder.
// The s_axis channel carries one byte of JSON text per transfer. For every
// input transfer exactly one result transfer leaves on m_axis: tdata holds
// the decoded byte (zero when none), tuser holds the byte-valid flag and a
// status code (continuing, string complete, error).
// The cfg channel writes the replacement byte used for \u escapes above
// 0x7F; it is always ready and should be written only while the block idles.
// Each byte passes an input register, combinational decode logic and a result
// register, so the result reaches m_axis through both registers in turn, and
// one byte per cycle is sustained while m_axis_tready stays high, limited only
// by the single decode step that updates the parse state.
// When m_axis_tready is low the result register holds, the input register
// still takes one more byte, and s_axis_tready then drops until the result
// is taken.
// Reset (aresetn low, synchronous) empties both registers, returns the
// parser to waiting for an opening quote and sets the replacement byte to '?'.
module json_string_unescape_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] decoded_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data        // [7:0] replacement_char
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    jsu_pkg::dec_result_t out_reg;
    logic [7:0]           repl_reg;
    jsu_pkg::dec_state_t  state_reg;
    jsu_pkg::dec_state_t  state_next;
    jsu_pkg::dec_result_t result_next;
    logic                 advance;

    // The buffered byte moves on when the result register is free or drains now.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.decoded_byte;
    assign m_axis_tuser  = {out_reg.status, out_reg.byte_valid};

    jsu_decode u_decode (
        .state_cur        (state_reg),
        .text_byte        (in_byte_reg),
        .replacement_char (repl_reg),
        .state_next       (state_next),
        .result           (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            repl_reg          <= jsu_pkg::REPL_RESET;
            state_reg.phase   <= jsu_pkg::PH_WAIT;
            state_reg.hex_cnt <= 2'd0;
            state_reg.hex_acc <= 16'd0;
        end else begin
            if (cfg_valid) begin
                repl_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

endmodule
